[rtl/core/hsaec_pkg.sv]
// Shared types and constants for the hall sensor averaging and event counting block.
package hsaec_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int SAMPLE_W   = 16;
    localparam int CMD_W      = 2;
    localparam int DEB_W      = 20;
    localparam int TICK_SHIFT = 4;
    localparam int PERIOD_W   = DEB_W - TICK_SHIFT;
    localparam int LOCK_W     = PERIOD_W + 1;
    localparam int TOTAL_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_SAMPLES);
    localparam int FLUX_W     = 16;
    localparam int COUNT_W    = 32;

    localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(100000);

    localparam int ZERO_OFFSET = (1020 * 1000) / 90;
    localparam int SCALE_MUL   = 5500;
    localparam int SCALE_DIV   = 2457;

    // mean * SCALE_MUL / SCALE_DIV as mean * SCALE_RECIP >> RECIP_SHIFT, exact for 16-bit means
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 30;
    localparam logic [RECIP_W-1:0] SCALE_RECIP =
        RECIP_W'((longint'(SCALE_MUL) * (longint'(1) << RECIP_SHIFT) + SCALE_DIV - 1)
                 / SCALE_DIV);
    localparam int PROD_W      = SAMPLE_W + RECIP_W;
    localparam int SCALED_W    = 18;
    localparam int DIFF_W      = SCALED_W + 2;

    localparam int DIV_W  = SUM_W;
    localparam int DVS_W  = TOTAL_W;
    localparam int DCNT_W = $clog2(DIV_W);

    localparam int IN_W     = 16;
    localparam int OUT_W    = 56;
    localparam int OUT_PAD_W = OUT_W - (FLUX_W + 1 + COUNT_W + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CROSS    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DEBOUNCE = 2'd3;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_TICK,
        OP_CROSS,
        OP_DEBOUNCE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/core/hsaec_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module hsaec_div (
    input  logic              clk,
    input  logic              rst_n,
    input  hsaec_pkg::div_req_t req,
    output hsaec_pkg::div_rsp_t rsp
);
    import hsaec_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/core/hsaec_front.sv]
// Input side: decodes the item kind and queues items for the back end.
module hsaec_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hsaec_pkg::IN_W-1:0]     s_tdata,
    input  logic [hsaec_pkg::CMD_W-1:0]    s_tuser,
    input  logic                           pop,
    output hsaec_pkg::q_head_t             head
);
    import hsaec_pkg::*;

    q_entry_t          fifo [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    q_entry_t          new_entry;

    always_comb
    begin
        case (s_tuser)
            CMD_SAMPLE:   new_entry.op = OP_SAMPLE;
            CMD_TICK:     new_entry.op = OP_TICK;
            CMD_CROSS:    new_entry.op = OP_CROSS;
            CMD_DEBOUNCE: new_entry.op = OP_DEBOUNCE;
            default:      new_entry.op = OP_DEBOUNCE;
        endcase
        new_entry.sample = s_tdata[SAMPLE_W-1:0];
    end

    assign s_tready = (cnt_reg != QCNT_W'(QDEPTH));
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.entry = fifo[rd_ptr_reg];

endmodule

[rtl/core/hsaec_back.sv]
// Execution side: accumulator, flux conversion sequencer, crossing counter and output register.
module hsaec_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hsaec_pkg::q_head_t            head,
    output logic                          pop,
    input  logic [hsaec_pkg::DEB_W-1:0]   debounce_us,
    output hsaec_pkg::div_req_t           div_req,
    input  hsaec_pkg::div_rsp_t           div_rsp,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hsaec_pkg::OUT_W-1:0]   m_tdata
);
    import hsaec_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_SCALE,
        ST_CONVERT
    } state_t;

    state_t               state_reg, state_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [FLUX_W-1:0]    flux_reg, flux_next;
    logic                 flux_ok_reg, flux_ok_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 armed_reg, armed_next;
    logic [LOCK_W-1:0]    lock_reg, lock_next;
    logic [SAMPLE_W-1:0]  mean_reg, mean_next;
    logic [SCALED_W-1:0]  scaled_reg, scaled_next;
    logic                 out_valid_reg, out_valid_next;

    logic [PERIOD_W-1:0]        period;
    logic [LOCK_W-1:0]          lock_len;
    logic [LOCK_W-1:0]          lock_inc;
    logic [PROD_W-1:0]          product;
    logic signed [DIFF_W-1:0]   diff;
    logic [FLUX_W-1:0]          flux_sat;

    localparam logic signed [DIFF_W-1:0] ZERO_OFFSET_D = DIFF_W'(ZERO_OFFSET);
    localparam logic signed [DIFF_W-1:0] FLUX_MIN_D    = DIFF_W'(-32768);
    localparam logic signed [DIFF_W-1:0] FLUX_MAX_D    = DIFF_W'(32767);

    always_comb
    begin
        period   = debounce_us[DEB_W-1:TICK_SHIFT];
        if (period == '0)
        begin
            period = PERIOD_W'(1);
        end
        lock_len = {1'b0, period} + 1'b1;
        lock_inc = lock_reg + 1'b1;
        product  = {{RECIP_W{1'b0}}, mean_reg} * {{SAMPLE_W{1'b0}}, SCALE_RECIP};
        diff     = ZERO_OFFSET_D - signed'({2'b00, scaled_reg});
        if (diff < FLUX_MIN_D)
        begin
            flux_sat = FLUX_MIN_D[FLUX_W-1:0];
        end
        else if (diff > FLUX_MAX_D)
        begin
            flux_sat = FLUX_MAX_D[FLUX_W-1:0];
        end
        else
        begin
            flux_sat = diff[FLUX_W-1:0];
        end
    end

    assign pop = (state_reg == ST_IDLE) && head.valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        total_next     = total_reg;
        flux_next      = flux_reg;
        flux_ok_next   = flux_ok_reg;
        count_next     = count_reg;
        armed_next     = armed_reg;
        lock_next      = lock_reg;
        mean_next      = mean_reg;
        scaled_next    = scaled_reg;
        out_valid_next = out_valid_reg && !m_tready;
        div_req        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    out_valid_next = 1'b1;
                    case (head.entry.op)
                        OP_SAMPLE:
                        begin
                            if (total_reg < TOTAL_W'(MAX_SAMPLES))
                            begin
                                sum_next   = sum_reg + SUM_W'(head.entry.sample);
                                total_next = total_reg + 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            sum_next   = '0;
                            total_next = '0;
                            if (total_reg == '0)
                            begin
                                flux_ok_next = 1'b0;
                            end
                            else
                            begin
                                out_valid_next   = 1'b0;
                                div_req.start    = 1'b1;
                                div_req.dividend = DIV_W'(sum_reg);
                                div_req.divisor  = DVS_W'(total_reg);
                                state_next       = ST_DIV_MEAN;
                            end
                        end
                        OP_CROSS:
                        begin
                            if (armed_reg)
                            begin
                                count_next = count_reg + 1'b1;
                                armed_next = 1'b0;
                                lock_next  = '0;
                            end
                        end
                        OP_DEBOUNCE:
                        begin
                            if (!armed_reg)
                            begin
                                if (lock_inc >= lock_len)
                                begin
                                    armed_next = 1'b1;
                                    lock_next  = '0;
                                end
                                else
                                begin
                                    lock_next = lock_inc;
                                end
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV_MEAN:
            begin
                if (div_rsp.done)
                begin
                    mean_next  = div_rsp.quotient[SAMPLE_W-1:0];
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                scaled_next = product[RECIP_SHIFT +: SCALED_W];
                state_next  = ST_CONVERT;
            end
            ST_CONVERT:
            begin
                flux_next      = flux_sat;
                flux_ok_next   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            total_reg     <= '0;
            flux_reg      <= '0;
            flux_ok_reg   <= 1'b0;
            count_reg     <= '0;
            armed_reg     <= 1'b1;
            lock_reg      <= '0;
            mean_reg      <= '0;
            scaled_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            total_reg     <= total_next;
            flux_reg      <= flux_next;
            flux_ok_reg   <= flux_ok_next;
            count_reg     <= count_next;
            armed_reg     <= armed_next;
            lock_reg      <= lock_next;
            mean_reg      <= mean_next;
            scaled_reg    <= scaled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, armed_reg, count_reg, flux_ok_reg, flux_reg};

endmodule

[rtl/core/hall_sensor_average_and_event_count_top.sv]
// Top level of the hall sensor averaging and event counting block.
//
// Input stream: s_tuser carries the item kind (sample, millisecond tick,
// comparator crossing, debounce tick), s_tdata the 16-bit ADC sample.
// Every accepted item yields exactly one result item on the output stream
// with the flux density, its valid flag, the event count and the armed bit.
// cfg_we/cfg_wdata load the debounce time; write it only while idle.
// A four-entry queue sits between the input decode and the execution unit.
// Samples, crossings and debounce ticks pass the queue and the execution
// unit's output register; a millisecond tick with samples runs the 26-bit
// mean divider at one quotient bit per cycle, then a reciprocal multiply and
// a saturate stage, and holds the execution unit until its result is registered.
// Throughput: one item per cycle except while a tick is being converted.
// A stalled output holds its item and stops the execution unit; the input
// keeps accepting until the queue is full.
// Reset: sums, counts and flux clear, the block comes up armed, the
// debounce time returns to 100000 us. No clearing pass is needed.
module hall_sensor_average_and_event_count_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hsaec_pkg::IN_W-1:0]      s_tdata,   // [15:0] sample
    input  logic [hsaec_pkg::CMD_W-1:0]     s_tuser,   // [1:0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hsaec_pkg::OUT_W-1:0]     m_tdata,   // [15:0] flux_density, [16] flux_valid,
                                                       // [48:17] event_count, [49] armed
    input  logic                            cfg_we,
    input  logic [hsaec_pkg::DEB_W-1:0]     cfg_wdata
);
    import hsaec_pkg::*;

    logic [DEB_W-1:0] debounce_reg;
    q_head_t          head;
    logic             pop;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEB_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_wdata;
        end
    end

    hsaec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .head     (head)
    );

    hsaec_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hsaec_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .debounce_us (debounce_reg),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!m_tvalid || m_tready))
        else $error("pop would overwrite a pending result");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> head.valid)
        else $error("accepted item not visible at queue head");

endmodule

[dv/tb_hall_sensor_average_and_event_count_top.sv]
// Testbench for hall_sensor_average_and_event_count_top: stream stimulus, flux/event scoreboard.
`timescale 1ns / 1ps

module tb_hall_sensor_average_and_event_count_top;

    import hsaec_pkg::*;

    typedef struct {
        logic [15:0] flux;
        logic        flux_valid;
        logic [31:0] event_count;
        logic        armed;
    } reading_t;

    class hall_scoreboard;
        logic [25:0]        sample_sum;
        logic [10:0]        sample_cnt;
        logic [15:0]        flux;
        logic               flux_ok;
        logic [31:0]        crossings;
        logic               armed;
        int unsigned        lockout;
        logic [DEB_W-1:0]   debounce;
        reading_t           expected_readings[$];
        int                 errors;

        function new();
            sample_sum = '0;
            sample_cnt = '0;
            flux       = '0;
            flux_ok    = 1'b0;
            crossings  = '0;
            armed      = 1'b1;
            lockout    = 0;
            debounce   = DEB_RESET;
            errors     = 0;
        endfunction

        function void set_debounce(logic [DEB_W-1:0] v);
            debounce = v;
        endfunction

        function int unsigned lockout_len();
            int unsigned p;
            p = debounce / 16;
            if (p > 65535)
                p = 65535;
            if (p < 1)
                p = 1;
            return p + 1;
        endfunction

        function void note_item(op_t op, logic [15:0] smp);
            longint mean;
            longint ut;
            reading_t r;
            case (op)
                OP_SAMPLE:
                begin
                    if (sample_cnt < MAX_SAMPLES)
                    begin
                        sample_sum = sample_sum + smp;
                        sample_cnt = sample_cnt + 1;
                    end
                end
                OP_TICK:
                begin
                    if (sample_cnt == 0)
                        flux_ok = 1'b0;
                    else
                    begin
                        mean = longint'(sample_sum) / longint'(sample_cnt);
                        ut = ZERO_OFFSET - (mean * SCALE_MUL) / SCALE_DIV;
                        if (ut > 32767)
                            ut = 32767;
                        if (ut < -32768)
                            ut = -32768;
                        flux    = ut[15:0];
                        flux_ok = 1'b1;
                    end
                    sample_sum = '0;
                    sample_cnt = '0;
                end
                OP_CROSS:
                begin
                    if (armed)
                    begin
                        crossings = crossings + 1;
                        armed     = 1'b0;
                        lockout   = 0;
                    end
                end
                default:
                begin
                    if (!armed)
                    begin
                        lockout++;
                        if (lockout >= lockout_len())
                        begin
                            armed   = 1'b1;
                            lockout = 0;
                        end
                    end
                end
            endcase
            r.flux        = flux;
            r.flux_valid  = flux_ok;
            r.event_count = crossings;
            r.armed       = armed;
            expected_readings.push_back(r);
        endfunction

        function void check_reading(logic [OUT_W-1:0] d);
            reading_t e;
            if (expected_readings.size() == 0)
            begin
                $error("result item with no expected item waiting");
                errors++;
                return;
            end
            e = expected_readings.pop_front();
            if (d[15:0] !== e.flux)
            begin
                $error("flux_density: expected %0d, got %0d", $signed(e.flux), $signed(d[15:0]));
                errors++;
            end
            if (d[16] !== e.flux_valid)
            begin
                $error("flux_valid: expected %0d, got %0d", e.flux_valid, d[16]);
                errors++;
            end
            if (d[48:17] !== e.event_count)
            begin
                $error("event_count: expected %0d, got %0d", e.event_count, d[48:17]);
                errors++;
            end
            if (d[49] !== e.armed)
            begin
                $error("armed: expected %0d, got %0d", e.armed, d[49]);
                errors++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata   = '0;
    logic [CMD_W-1:0]   s_tuser   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               cfg_we    = 1'b0;
    logic [DEB_W-1:0]   cfg_wdata = '0;

    hall_scoreboard sb = new();

    int rx_mode    = 0;
    int rx_cycle   = 0;
    bit tx_idling  = 1'b0;
    int burst_left = 0;

    always #5 clk = ~clk;

    hall_sensor_average_and_event_count_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // receiver stall pattern
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_cycle % 11) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_item(op_t'(s_tuser), s_tdata);
        if (m_tvalid && m_tready)
            sb.check_reading(m_tdata);
    end

    initial
    begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(op_t op, logic [15:0] smp);
        int gap;
        if (tx_idling && burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold off until every expected item is back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_debounce(logic [DEB_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_debounce(v);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(4000, 6000));
            3: return 16'($urandom_range(0, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(int n_items, logic [DEB_W-1:0] deb, int mode, bit gaps,
                             bit long_block);
        int sent;
        int len;
        settle();
        write_debounce(deb);
        rx_mode   = mode;
        tx_idling = gaps;
        sent = 0;
        if (long_block)
        begin
            len = MAX_SAMPLES + $urandom_range(1, 40);
            repeat (len) send_item(OP_SAMPLE, pick_sample());
            send_item(OP_TICK, 16'($urandom));
        end
        while (sent < n_items)
        begin
            len = $urandom_range(0, 99);
            if (len < 50)
            begin
                len = $urandom_range(1, 12);
                repeat (len) send_item(OP_SAMPLE, pick_sample());
                send_item(OP_TICK, 16'($urandom));
                sent += len + 1;
            end
            else if (len < 70)
            begin
                send_item(OP_CROSS, 16'($urandom));
                len = $urandom_range(0, sb.lockout_len() > 14 ? 16 : sb.lockout_len() + 2);
                repeat (len) send_item(OP_DEBOUNCE, 16'($urandom));
                sent += len + 1;
            end
            else if (len < 80)
            begin
                send_item(OP_DEBOUNCE, 16'($urandom));
                sent++;
            end
            else if (len < 88)
            begin
                send_item(OP_TICK, 16'($urandom));
                sent++;
            end
            else
            begin
                send_item(op_t'($urandom_range(0, 3)), 16'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick, extremes, lost crossing, ignored debounce
        write_debounce(20'd47);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_SAMPLE, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_SAMPLE, 16'hFFFF);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_SAMPLE, 16'd5063);
        send_item(OP_SAMPLE, 16'd5064);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_DEBOUNCE, 16'hFFFF);
        send_item(OP_CROSS, 16'hFFFF);
        send_item(OP_CROSS, 16'h0000);
        send_item(OP_DEBOUNCE, 16'h0000);
        send_item(OP_DEBOUNCE, 16'h0000);
        // shorten lockout midway
        settle();
        write_debounce(20'd0);
        send_item(OP_DEBOUNCE, 16'h0000);
        send_item(OP_CROSS, 16'h0000);
        send_item(OP_DEBOUNCE, 16'h0000);
        send_item(OP_DEBOUNCE, 16'h0000);
        send_item(OP_CROSS, 16'h0000);

        run_phase(180, 20'd0, 1, 1'b1, 1'b0);
        run_phase(180, 20'd100, 3, 1'b0, 1'b1);
        run_phase(180, 20'hFFFFF, 2, 1'b1, 1'b0);
        run_phase(180, 20'd32, 0, 1'b1, 1'b0);
        run_phase(180, 20'd160, 1, 1'b1, 1'b0);

        settle();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.expected_readings.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/core/hsaec_pkg.sv
rtl/core/hsaec_div.sv
rtl/core/hsaec_front.sv
rtl/core/hsaec_back.sv
rtl/core/hall_sensor_average_and_event_count_top.sv
dv/tb_hall_sensor_average_and_event_count_top.sv
